### rtl/rn_pkg.sv
package rn_pkg;

	localparam int RN_NUM_W  = 12;
	localparam int RN_CHAR_W = 8;
	localparam int RN_TOKENS = 13;

	localparam logic [RN_NUM_W-1:0] RN_LIMIT = 12'd3999;

	localparam logic [RN_CHAR_W-1:0] RN_CH_NONE = 8'h00;
	localparam logic [RN_CHAR_W-1:0] RN_CH_M    = 8'h4D;
	localparam logic [RN_CHAR_W-1:0] RN_CH_D    = 8'h44;
	localparam logic [RN_CHAR_W-1:0] RN_CH_C    = 8'h43;
	localparam logic [RN_CHAR_W-1:0] RN_CH_L    = 8'h4C;
	localparam logic [RN_CHAR_W-1:0] RN_CH_X    = 8'h58;
	localparam logic [RN_CHAR_W-1:0] RN_CH_V    = 8'h56;
	localparam logic [RN_CHAR_W-1:0] RN_CH_I    = 8'h49;

	typedef enum logic [0:0] {
		RN_IDLE,
		RN_CONV
	} rn_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} rn_cmd_t;

	typedef struct packed {
		logic last;
	} rn_stat_t;

	// One numeral token: a single symbol, or a subtractive pair of two symbols.
	typedef struct packed {
		logic [RN_NUM_W-1:0]  val;
		logic [RN_CHAR_W-1:0] lead;
		logic [RN_CHAR_W-1:0] second;
		logic                 pair;
	} rn_tok_t;

	localparam logic [RN_NUM_W-1:0] RN_TOK_VAL [RN_TOKENS] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	localparam logic [RN_CHAR_W-1:0] RN_TOK_LEAD [RN_TOKENS] = '{
		RN_CH_M, RN_CH_C, RN_CH_D, RN_CH_C, RN_CH_C, RN_CH_X, RN_CH_L,
		RN_CH_X, RN_CH_X, RN_CH_I, RN_CH_V, RN_CH_I, RN_CH_I
	};

	localparam logic [RN_CHAR_W-1:0] RN_TOK_SECOND [RN_TOKENS] = '{
		RN_CH_NONE, RN_CH_M, RN_CH_NONE, RN_CH_D, RN_CH_NONE, RN_CH_C, RN_CH_NONE,
		RN_CH_L, RN_CH_NONE, RN_CH_X, RN_CH_NONE, RN_CH_V, RN_CH_NONE
	};

	localparam logic RN_TOK_PAIR [RN_TOKENS] = '{
		1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
	};

	// Largest token not above the remainder. The compares are independent;
	// scanning from the smallest up lets the largest match win.
	function automatic rn_tok_t rn_lookup(input logic [RN_NUM_W-1:0] rem);
		rn_tok_t tok;
		tok.val    = RN_TOK_VAL[RN_TOKENS-1];
		tok.lead   = RN_TOK_LEAD[RN_TOKENS-1];
		tok.second = RN_TOK_SECOND[RN_TOKENS-1];
		tok.pair   = RN_TOK_PAIR[RN_TOKENS-1];
		for (int i = RN_TOKENS - 1; i >= 0; i--) begin
			if (rem >= RN_TOK_VAL[i]) begin
				tok.val    = RN_TOK_VAL[i];
				tok.lead   = RN_TOK_LEAD[i];
				tok.second = RN_TOK_SECOND[i];
				tok.pair   = RN_TOK_PAIR[i];
			end
		end
		return tok;
	endfunction

endpackage

### rtl/rn_ctrl.sv
module rn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rn_pkg::rn_cmd_t  cmd,
	input  rn_pkg::rn_stat_t stat
);

	rn_pkg::rn_state_t state_q;
	rn_pkg::rn_state_t state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rn_pkg::RN_IDLE: begin
				if (in_valid) state_d = rn_pkg::RN_CONV;
			end
			rn_pkg::RN_CONV: begin
				if (out_free && stat.last) state_d = rn_pkg::RN_IDLE;
			end
			default: state_d = rn_pkg::RN_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		unique case (state_q)
			rn_pkg::RN_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rn_pkg::RN_CONV: begin
				cmd.step = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rn_pkg::RN_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/rn_dp.sv
module rn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rn_pkg::rn_cmd_t              cmd,
	output rn_pkg::rn_stat_t             stat,
	input  logic [rn_pkg::RN_NUM_W-1:0]  number,
	output logic [rn_pkg::RN_CHAR_W-1:0] symbol_char,
	output logic                         last_symbol,
	output logic                         empty_result,
	output logic                         out_of_range
);

	logic [rn_pkg::RN_NUM_W-1:0]  rem_q;
	logic [rn_pkg::RN_NUM_W-1:0]  rem_sub;
	logic                         pend_q;
	logic [rn_pkg::RN_CHAR_W-1:0] pend_char_q;
	logic                         zero_q;
	logic                         oor_q;
	rn_pkg::rn_tok_t              tok;

	logic [rn_pkg::RN_CHAR_W-1:0] char_d;
	logic                         last_d;
	logic                         empty_d;
	logic                         oor_d;

	logic [rn_pkg::RN_CHAR_W-1:0] out_char_q;
	logic                         out_last_q;
	logic                         out_empty_q;
	logic                         out_oor_q;

	always_comb begin
		tok     = rn_pkg::rn_lookup(rem_q);
		rem_sub = rem_q - tok.val;
	end

	// The second symbol of a subtractive pair goes out before the next lookup.
	always_comb begin
		char_d  = tok.lead;
		last_d  = !tok.pair && (rem_sub == '0);
		empty_d = 1'b0;
		oor_d   = 1'b0;
		if (pend_q) begin
			char_d = pend_char_q;
			last_d = (rem_q == '0);
		end else if (zero_q || oor_q) begin
			char_d  = rn_pkg::RN_CH_NONE;
			last_d  = 1'b1;
			empty_d = zero_q;
			oor_d   = oor_q;
		end
	end

	assign stat.last = last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			zero_q <= 1'b0;
			oor_q  <= 1'b0;
		end else if (cmd.load) begin
			pend_q <= 1'b0;
			zero_q <= (number == '0);
			oor_q  <= (number > rn_pkg::RN_LIMIT);
		end else if (cmd.step) begin
			if (pend_q) pend_q <= 1'b0;
			else if (!zero_q && !oor_q) pend_q <= tok.pair;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= number;
		end else if (cmd.step && !pend_q && !zero_q && !oor_q) begin
			rem_q       <= rem_sub;
			pend_char_q <= tok.second;
		end
		if (cmd.step) begin
			out_char_q  <= char_d;
			out_last_q  <= last_d;
			out_empty_q <= empty_d;
			out_oor_q   <= oor_d;
		end
	end

	assign symbol_char  = out_char_q;
	assign last_symbol  = out_last_q;
	assign empty_result = out_empty_q;
	assign out_of_range = out_oor_q;

endmodule

### rtl/integer_to_roman_numeral_top.sv
// Channel  Direction  tdata                      tlast        tuser
// s_axis   in         [11:0] number, [15:12] 0   -            -
// m_axis   out        [7:0] symbol_char          last_symbol  [0] empty_result, [1] out_of_range
//
// An item is taken in the idle state, then one character leaves per cycle, while
// m_tready does not stall, from a token lookup on the remainder; the next item
// is taken only after the last character of the item has been registered.
// Reset clears the controller and the output valid; no request is in flight after it.
// A low m_tready while m_tvalid is high holds the output register and pauses the conversion.
module integer_to_roman_numeral_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] number, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] symbol_char
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [0] empty_result, [1] out_of_range
);

	rn_pkg::rn_cmd_t  cmd;
	rn_pkg::rn_stat_t stat;

	rn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rn_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.number      (s_tdata[rn_pkg::RN_NUM_W-1:0]),
		.symbol_char (m_tdata),
		.last_symbol (m_tlast),
		.empty_result(m_tuser[0]),
		.out_of_range(m_tuser[1])
	);

endmodule

### rtl/rn_chk.sv
module rn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// Once a request is taken the block is busy converting it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// A flagged result stands alone and carries no character.
	a_flag_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 2'b00) |-> m_tlast && (m_tdata == 8'h00))
		else $error("flagged result is not a lone empty result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 2'b11))
		else $error("empty and out of range both set");

	a_char_or_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == 8'h00) |-> (m_tuser != 2'b00))
		else $error("null character without a flag");

endmodule

bind integer_to_roman_numeral_top rn_chk u_rn_chk (.*);
